FILE: sv/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// shared constants and types of the lru key/value cache
// ----------------------------------------------------------------------------
package lru_pkg;

	localparam int unsigned EntriesDefault = 16;
	localparam int unsigned KeyWidth       = 32;
	localparam int unsigned ValueWidth     = 32;
	localparam int unsigned CapWidth       = 5;
	localparam logic [CapWidth-1:0] CapReset = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} state_t;

	typedef enum logic {
		MODE_GET = 1'b0,
		MODE_PUT = 1'b1
	} mode_t;

endpackage

FILE: sv/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// fully associative key/value cache with least recently used replacement
// ----------------------------------------------------------------------------
// input beats on s_axis carry a get (tuser 0) or a put (tuser 1) with key and
// value in tdata; every beat yields exactly one result beat on m_axis with
// hit and evicted in tuser and the read value in tdata.
// keys, values and recency ranks sit in one synchronous memory per field;
// an access reads each slot in turn, one slot a cycle, comparing keys and
// tracking the oldest entry, then writes back the changed key, value and
// ranks in a second sweep of one slot a cycle.
// the result beat is offered after both sweeps, and a new input beat is
// taken only once the core is back in its idle state.
// the next beat is accepted once the result is registered, so it overlaps a
// result that is still waiting on m_axis.
// reset empties the store (valid bits and the fill count clear at once) and
// sets capacity to 16; configuration writes keep the contents.
// a stalled receiver holds the result beat; the core then takes at most one
// more input and waits with its result until the first is taken.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
	parameter int unsigned ENTRIES = lru_pkg::EntriesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel: capacity
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// tdata: lookup_key[31:0], write_value[63:32]
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,
	// tuser: mode
	input  logic        s_axis_tuser,
	// tdata: read_value[31:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,
	// tuser: hit[0], evicted[1]
	output logic [1:0]  m_axis_tuser
);

	localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned RankW = IdxW;
	localparam int unsigned CntW = $clog2(ENTRIES + 1);
	localparam int unsigned KW = lru_pkg::KeyWidth;
	localparam int unsigned VW = lru_pkg::ValueWidth;
	localparam int unsigned CW = lru_pkg::CapWidth;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

	lru_pkg::state_t state_q;
	logic            phase_q;        // 0 = scan sweep, 1 = write-back sweep
	logic [IdxW:0]   ptr_q;          // read address / step counter
	logic            rd_vld_q;       // memory data valid for slot rd_idx_q
	logic [IdxW-1:0] rd_idx_q;

	logic [CW-1:0]   cap_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CntW-1:0] fill_q;

	logic            put_q;
	logic [KW-1:0]   key_q;
	logic [VW-1:0]   val_q;

	logic            found_q;
	logic [IdxW-1:0] slot_q;
	logic [RankW-1:0] slot_rank_q;
	logic [VW-1:0]   hit_val_q;
	logic            any_q;
	logic [IdxW-1:0] worst_q;
	logic [RankW-1:0] worst_rank_q;
	logic [IdxW-1:0] free_q;
	logic            free_any_q;

	// decision taken between the sweeps
	logic            wr_en_q;        // new key written to target on a put miss
	logic [IdxW-1:0] tgt_q;
	logic [RankW-1:0] thr_q;         // entries below this rank age by one
	logic            all_age_q;      // insert: every valid entry ages
	logic            ins_q;
	logic            evict_q;

	logic            out_vld_q;
	logic [VW-1:0]   out_val_q;
	logic            out_hit_q;
	logic            out_ev_q;

	// memories
	logic            key_we, val_we, rank_we;
	logic [IdxW-1:0] waddr;
	logic [KW-1:0]   key_rd;
	logic [VW-1:0]   val_rd;
	logic [RankW-1:0] rank_rd, rank_wd;
	logic [VW-1:0]   val_wd;
	logic [IdxW-1:0] raddr;

	assign raddr = ptr_q[IdxW-1:0];

	lru_ram #(.WIDTH(KW), .DEPTH(ENTRIES)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(waddr), .wdata(key_q),
		.raddr(raddr), .rdata(key_rd)
	);
	lru_ram #(.WIDTH(VW), .DEPTH(ENTRIES)) u_val_ram (
		.clk(clk), .we(val_we), .waddr(waddr), .wdata(val_wd),
		.raddr(raddr), .rdata(val_rd)
	);
	lru_ram #(.WIDTH(RankW), .DEPTH(ENTRIES)) u_rank_ram (
		.clk(clk), .we(rank_we), .waddr(waddr), .wdata(rank_wd),
		.raddr(raddr), .rdata(rank_rd)
	);

	// effective capacity: zero acts as one, saturate at the store size
	logic [CntW:0] eff_cap;
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = (CntW+1)'(1);
		end else if ({{(CntW+1){1'b0}}, cap_q} > (CntW+1+CW)'(ENTRIES)) begin
			eff_cap = (CntW+1)'(ENTRIES);
		end else begin
			eff_cap = (CntW+1)'(cap_q);
		end
	end

	// handshakes
	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == lru_pkg::ST_IDLE);
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_val_q;
	assign m_axis_tuser  = {out_ev_q, out_hit_q};

	logic in_beat;
	assign in_beat = s_axis_tvalid && s_axis_tready;

	// write-back sweep: slot rd_idx_q, memory data is its old rank
	logic [RankW-1:0] new_rank;
	logic             rd_valid_slot;
	assign rd_valid_slot = valid_q[rd_idx_q];
	always_comb begin
		new_rank = rank_rd;
		if (rd_idx_q == tgt_q) begin
			new_rank = '0;
		end else if (rd_valid_slot && (all_age_q || rank_rd < thr_q)) begin
			new_rank = rank_rd + RankW'(1);
		end
	end

	always_comb begin
		waddr   = rd_idx_q;
		rank_wd = new_rank;
		val_wd  = val_q;
		rank_we = (state_q == lru_pkg::ST_SCAN) && phase_q && rd_vld_q &&
			(wr_en_q || found_q);
		key_we  = rank_we && wr_en_q && (rd_idx_q == tgt_q);
		val_we  = rank_we && put_q && (rd_idx_q == tgt_q);
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lru_pkg::ST_IDLE;
			phase_q   <= 1'b0;
			ptr_q     <= '0;
			rd_vld_q  <= 1'b0;
			cap_q     <= lru_pkg::CapReset;
			valid_q   <= '0;
			fill_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data[CW-1:0];
			end
			if (out_vld_q && m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				lru_pkg::ST_IDLE: begin
					if (in_beat) begin
						state_q  <= lru_pkg::ST_SCAN;
						phase_q  <= 1'b0;
						ptr_q    <= '0;
						rd_vld_q <= 1'b0;
					end
				end
				lru_pkg::ST_SCAN: begin
					rd_vld_q <= (ptr_q < (IdxW+1)'(ENTRIES));
					if (ptr_q < (IdxW+1)'(ENTRIES)) begin
						ptr_q <= ptr_q + (IdxW+1)'(1);
					end
					if (ptr_q == (IdxW+1)'(ENTRIES) && !rd_vld_q) begin
						if (!phase_q) begin
							phase_q <= 1'b1;
							ptr_q   <= '0;
						end else begin
							state_q <= lru_pkg::ST_RESULT;
						end
					end
					if (phase_q && rd_vld_q && rd_idx_q == LastIdx && ins_q) begin
						valid_q[tgt_q] <= 1'b1;
						fill_q         <= fill_q + CntW'(1);
					end
				end
				lru_pkg::ST_RESULT: begin
					if (!out_vld_q || m_axis_tready) begin
						out_vld_q <= 1'b1;
						state_q   <= lru_pkg::ST_IDLE;
					end
				end
				default: state_q <= lru_pkg::ST_IDLE;
			endcase
		end
	end

	// datapath: capture, scan and decision
	always_ff @(posedge clk) begin
		rd_idx_q <= raddr;
		if (in_beat) begin
			put_q      <= (s_axis_tuser == lru_pkg::MODE_PUT);
			key_q      <= s_axis_tdata[KW-1:0];
			val_q      <= s_axis_tdata[KW+VW-1:KW];
			found_q    <= 1'b0;
			any_q      <= 1'b0;
			free_any_q <= 1'b0;
			slot_q     <= '0;
			slot_rank_q <= '0;
			hit_val_q  <= '0;
			worst_q    <= '0;
			worst_rank_q <= '0;
			free_q     <= '0;
		end
		// scan sweep: match, oldest entry and lowest free slot
		if (state_q == lru_pkg::ST_SCAN && !phase_q && rd_vld_q) begin
			if (valid_q[rd_idx_q]) begin
				if (key_rd == key_q && !found_q) begin
					found_q     <= 1'b1;
					slot_q      <= rd_idx_q;
					slot_rank_q <= rank_rd;
					hit_val_q   <= val_rd;
				end
				if (!any_q || rank_rd > worst_rank_q) begin
					any_q        <= 1'b1;
					worst_q      <= rd_idx_q;
					worst_rank_q <= rank_rd;
				end
			end else if (!free_any_q) begin
				free_any_q <= 1'b1;
				free_q     <= rd_idx_q;
			end
		end
		// decision at the turn between sweeps
		if (state_q == lru_pkg::ST_SCAN && !phase_q &&
				ptr_q == (IdxW+1)'(ENTRIES) && !rd_vld_q) begin
			wr_en_q   <= 1'b0;
			ins_q     <= 1'b0;
			evict_q   <= 1'b0;
			all_age_q <= 1'b0;
			tgt_q     <= slot_q;
			thr_q     <= slot_rank_q;
			if (found_q) begin
				tgt_q <= slot_q;
			end else if (put_q) begin
				if ({1'b0, fill_q} >= eff_cap && any_q) begin
					wr_en_q <= 1'b1;
					evict_q <= 1'b1;
					tgt_q   <= worst_q;
					thr_q   <= worst_rank_q;
				end else if (free_any_q) begin
					wr_en_q   <= 1'b1;
					ins_q     <= 1'b1;
					all_age_q <= 1'b1;
					tgt_q     <= free_q;
				end
			end
		end
		// result register
		if (state_q == lru_pkg::ST_RESULT && (!out_vld_q || m_axis_tready)) begin
			out_hit_q <= found_q;
			out_val_q <= (found_q && !put_q) ? hit_val_q : '0;
			out_ev_q  <= evict_q;
		end
	end

endmodule

FILE: sv/lru_ram.sv
// ----------------------------------------------------------------------------
// lru_ram
// generic single-port write, single-port read ram with registered read
// ----------------------------------------------------------------------------
module lru_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                              wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks the lru key/value cache core against its own recency-ordered store
// ----------------------------------------------------------------------------
// gets and puts go in on s_axis in bursts with random gaps; every result beat
// on m_axis is compared with the value, hit and eviction flag worked out by a
// small behavioural store in the bench. capacity is changed between phases
// while the core is idle, including zero, one, sixteen and values above it.
// ----------------------------------------------------------------------------
module tb;

	localparam int NSLOT = 16;

	// expected result of one access
	typedef struct packed {
		logic        hit;
		logic [31:0] rd;
		logic        evicted;
	} access_result_t;

	// behavioural store and queue of expected results
	class lru_scoreboard;
		bit          vld [NSLOT];
		logic [31:0] keys [NSLOT];
		logic [31:0] vals [NSLOT];
		int          rank [NSLOT];
		int          fill;
		int          cap;
		access_result_t pending[$];
		int          errors;

		function void clear();
			foreach (vld[i]) begin
				vld[i] = 0; rank[i] = 0;
			end
			fill = 0; cap = 16; errors = 0;
		endfunction

		function void set_cap(logic [4:0] c);
			cap = (c == 0) ? 1 : ((c > NSLOT) ? NSLOT : c);
		endfunction

		function void make_recent(int s);
			foreach (vld[i])
				if (vld[i] && i != s && rank[i] < rank[s]) rank[i]++;
			rank[s] = 0;
		endfunction

		// note an accepted access and predict its result
		function void note_access(lru_pkg::mode_t m, logic [31:0] k, logic [31:0] v);
			access_result_t r;
			int slot, oldest;
			r = '0; slot = -1; oldest = -1;
			foreach (vld[i])
				if (slot < 0 && vld[i] && keys[i] == k) slot = i;
			r.hit = (slot >= 0);
			if (slot >= 0) begin
				if (m == lru_pkg::MODE_GET) r.rd = vals[slot];
				else vals[slot] = v;
				make_recent(slot);
			end else if (m == lru_pkg::MODE_PUT) begin
				if (fill >= cap) begin
					foreach (vld[i])
						if (vld[i] && (oldest < 0 || rank[i] > rank[oldest])) oldest = i;
				end
				if (oldest >= 0) begin
					keys[oldest] = k; vals[oldest] = v;
					make_recent(oldest);
					r.evicted = 1;
				end else begin
					foreach (vld[i])
						if (slot < 0 && !vld[i]) slot = i;
					foreach (vld[i])
						if (vld[i]) rank[i]++;
					vld[slot] = 1; keys[slot] = k; vals[slot] = v;
					rank[slot] = 0; fill++;
				end
			end
			pending.push_back(r);
		endfunction

		// compare one result beat with the oldest expectation
		function void check_result(logic [31:0] rd, logic [1:0] flags);
			access_result_t e;
			if (pending.size() == 0) begin
				$error("unexpected result beat");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (flags[0] !== e.hit) begin
				$error("hit: expected %0d, got %0d", e.hit, flags[0]); errors++;
			end
			if (rd !== e.rd) begin
				$error("read_value: expected %h, got %h", e.rd, rd); errors++;
			end
			if (flags[1] !== e.evicted) begin
				$error("evicted: expected %0d, got %0d", e.evicted, flags[1]); errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = '0;
	logic        s_axis_tvalid = 0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	lru_scoreboard sb = new();
	bit          hold_off = 0;
	bit          stall_en = 1;
	logic [31:0] key_pool [8];

	always #1 clk = ~clk;

	lru_key_value_cache_core u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	// receiver: stall pattern plus an optional long hold-off
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
		m_axis_tready <= !hold_off && (!stall_en || ($urandom_range(0, 3) != 0));
	end

	// one input beat, valid kept high across back-to-back beats
	task automatic send_access(lru_pkg::mode_t m, logic [31:0] k, logic [31:0] v);
		s_axis_tvalid <= 1;
		s_axis_tuser  <= m;
		s_axis_tdata  <= {v, k};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_access(m, k, v);
	endtask

	task automatic pause_sender(int n);
		s_axis_tvalid <= 0;
		repeat (n) @(posedge clk);
	endtask

	// idle the input, drain results, then write capacity
	task automatic write_capacity(logic [7:0] c);
		pause_sender(1);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_valid <= 1;
		cfg_data  <= c;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.set_cap(c[4:0]);
	endtask

	function automatic logic [31:0] pick_key();
		if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, 7)];
		return $urandom();
	endfunction

	// random phase: bursts of mostly reused keys
	task automatic random_phase(int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && n > 0) begin
				send_access(lru_pkg::mode_t'($urandom_range(0, 1)), pick_key(), $urandom());
				burst--; n--;
			end
			if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 50));
		end
	endtask

	initial begin
		int cycles;
		sb.clear();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes of keys and values, hits, misses, updates
		send_access(lru_pkg::MODE_GET, 32'h0, 32'hffff_ffff);
		send_access(lru_pkg::MODE_PUT, 32'h8000_0000, 32'h7fff_ffff);
		send_access(lru_pkg::MODE_PUT, 32'h7fff_ffff, 32'h8000_0000);
		send_access(lru_pkg::MODE_PUT, 32'hffff_ffff, 32'hffff_ffff);
		send_access(lru_pkg::MODE_PUT, 32'h0, 32'h0);
		send_access(lru_pkg::MODE_GET, 32'h8000_0000, 32'h0);
		send_access(lru_pkg::MODE_GET, 32'hffff_ffff, 32'h0);
		send_access(lru_pkg::MODE_PUT, 32'h7fff_ffff, 32'h1234_5678);
		send_access(lru_pkg::MODE_GET, 32'h7fff_ffff, 32'h0);
		send_access(lru_pkg::MODE_GET, 32'h1, 32'h0);
		for (int i = 0; i < 14; i++)
			send_access(lru_pkg::MODE_PUT, 32'h100 + i, 32'ha5a5_0000 + i);

		// capacity lowered below the fill: each new key evicts one
		write_capacity(8'd3);
		send_access(lru_pkg::MODE_PUT, 32'hdead_beef, 32'h1);
		send_access(lru_pkg::MODE_GET, 32'h100, 32'h0);
		send_access(lru_pkg::MODE_PUT, 32'hcafe_f00d, 32'h2);

		// capacity settings with random traffic on a small key pool
		foreach (key_pool[i]) key_pool[i] = $urandom();
		write_capacity(8'd0);
		random_phase(60);
		write_capacity(8'd1);
		random_phase(60);
		foreach (key_pool[i]) key_pool[i] = $urandom();
		write_capacity(8'd31);
		random_phase(80);
		write_capacity(8'd16);
		for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
		random_phase(80);
		write_capacity(8'd4);
		random_phase(80);
		write_capacity(8'd17);
		random_phase(60);

		// long receiver hold-off while the sender keeps offering beats
		fork
			begin
				hold_off = 1;
				cycles = 0;
				while (cycles < 300) begin
					@(posedge clk);
					cycles++;
				end
				hold_off = 0;
			end
			random_phase(20);
		join
		stall_en = 0;
		random_phase(60);
		stall_en = 1;
		write_capacity(8'd7);
		random_phase(120);

		pause_sender(1);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#400000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
